>>> src/sse_pkg.sv
// Shared types, constants and the reciprocal table of the sine series evaluator.
package sse_pkg;

   // Series length and derived widths
   localparam int MAX_TERMS = 32;
   localparam int TERM_W    = $clog2(MAX_TERMS + 1);
   localparam int IDX_W     = $clog2(MAX_TERMS);

   // Fixed-point widths: term magnitude Q17.30, signed accumulator
   localparam int MAG_W   = 47;
   localparam int ACC_W   = 48;
   localparam int OPA_W   = 48;
   localparam int DIGIT_W = 16;
   localparam int PROD_W  = 96;

   localparam logic [MAG_W-1:0] MAG_MAX = {MAG_W{1'b1}};
   localparam logic signed [ACC_W:0] ACC_HI = $signed({2'b00, MAG_MAX});
   localparam logic signed [ACC_W:0] ACC_LO = -ACC_HI;
   localparam logic signed [ACC_W-1:0] ONE_Q30 = 48'sh0000_4000_0000;
   localparam logic signed [ACC_W-1:0] NEG_ONE_Q30 = -ONE_Q30;

   // Sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SQ,
      ST_SQ_END,
      ST_ACC,
      ST_MX,
      ST_MX_END,
      ST_MR,
      ST_MR_END,
      ST_OUT
   } state_type;

   // Rounding shift applied to the finished product
   typedef enum logic [1:0] {
      SH_26,
      SH_30,
      SH_32
   } shift_type;

   // Control group for the shared multiplier
   typedef struct packed {
      logic      step;
      logic      clear;
      shift_type shift;
   } mul_ctrl_type;

   typedef logic [31:0] recip_table_type [MAX_TERMS];

   // Rounded Q0.32 reciprocal of (2k)(2k+1) by restoring long division
   function automatic logic [31:0] recip_entry(input int unsigned k);
      logic [63:0] d;
      logic [63:0] num;
      logic [63:0] rem;
      logic [63:0] quo;
      d   = 64'(2 * k) * 64'(2 * k + 1);
      num = (64'd1 << 32) + (d >> 1);
      rem = '0;
      quo = '0;
      for (int b = 63; b >= 0; b--) begin
         rem = {rem[62:0], num[b]};
         if (rem >= d) begin
            rem    = rem - d;
            quo[b] = 1'b1;
         end
      end
      return quo[31:0];
   endfunction

   // Rounded Q0.32 reciprocals of (2k)(2k+1), entry zero unused
   function automatic recip_table_type build_recip();
      recip_table_type t;
      t[0] = '0;
      for (int k = 1; k < MAX_TERMS; k++) begin
         t[k] = recip_entry(k);
      end
      return t;
   endfunction

   localparam recip_table_type RECIP = build_recip();

endpackage

>>> src/sse_mul_unit.sv
// Shared digit-serial multiplier with rounding and magnitude saturation.
module sse_mul_unit (
   input  logic                        clock,
   input  sse_pkg::mul_ctrl_type       ctrl,
   input  logic [sse_pkg::OPA_W-1:0]   op_a,
   input  logic [sse_pkg::DIGIT_W-1:0] op_digit,
   output logic [sse_pkg::MAG_W-1:0]   result
);

   logic [sse_pkg::PROD_W-1:0]                 prod_ff;
   logic [sse_pkg::PROD_W-1:0]                 prod_in;
   logic [sse_pkg::OPA_W+sse_pkg::DIGIT_W-1:0] partial;
   logic [sse_pkg::PROD_W:0]                   half;
   logic [sse_pkg::PROD_W:0]                   rounded;
   logic [sse_pkg::PROD_W:0]                   shifted;

   // Shift in one digit, most significant digit first
   assign partial = op_a * op_digit;
   assign prod_in = (ctrl.clear ? '0 : (prod_ff << sse_pkg::DIGIT_W))
                  + sse_pkg::PROD_W'(partial);

   always_ff @(posedge clock) begin
      if (ctrl.step) begin
         prod_ff <= prod_in;
      end
   end

   // Round half up at the selected binary point
   always_comb begin
      case (ctrl.shift)
         sse_pkg::SH_26: half = (sse_pkg::PROD_W+1)'(1) << 25;
         sse_pkg::SH_30: half = (sse_pkg::PROD_W+1)'(1) << 29;
         default:        half = (sse_pkg::PROD_W+1)'(1) << 31;
      endcase
   end

   assign rounded = {1'b0, prod_ff} + half;

   always_comb begin
      case (ctrl.shift)
         sse_pkg::SH_26: shifted = rounded >> 26;
         sse_pkg::SH_30: shifted = rounded >> 30;
         default:        shifted = rounded >> 32;
      endcase
   end

   // Saturate the magnitude
   assign result = (shifted > (sse_pkg::PROD_W+1)'(sse_pkg::MAG_MAX)) ? sse_pkg::MAG_MAX
                 : shifted[sse_pkg::MAG_W-1:0];

endmodule

>>> src/sine_series_evaluator.sv
// Top level of the sine series evaluator: sequencer, accumulator and result registers.
// An item summing n terms keeps busy high after start is taken until its result is registered;
// the result strobe follows in the next cycle. Each term needs two products on the one
// shared 48x16 multiplier (three plus two digits, each followed by a rounding state).
// A new item is taken only while idle; start may be taken during the strobe cycle.
// Reset: synchronous; clears the sequencer and sets stop_threshold to 1.
module sine_series_evaluator (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [31:0] req_angle,
   input  logic        csr_wr_en,
   input  logic [20:0] csr_wr_data,
   output logic        rsp_valid,
   output logic [31:0] rsp_sine_value,
   output logic [5:0]  rsp_terms_used,
   output logic        rsp_not_converged
);

   sse_pkg::state_type state_ff, state_in;

   logic [20:0]                     thr_ff;
   logic [1:0]                      dig_ff;
   logic [sse_pkg::TERM_W-1:0]      used_ff;
   logic                            done_ff;
   logic [31:0]                     amag_ff;
   logic [36:0]                     x2_ff;
   logic [sse_pkg::MAG_W-1:0]       m_ff;
   logic                            tneg_ff;
   logic signed [sse_pkg::ACC_W-1:0] acc_ff;

   logic                            rsp_valid_ff;
   logic [31:0]                     rsp_sine_ff;
   logic [5:0]                      rsp_terms_ff;
   logic                            rsp_nc_ff;

   sse_pkg::mul_ctrl_type           mul_ctrl;
   logic [sse_pkg::OPA_W-1:0]       mul_a;
   logic [47:0]                     b_word;
   logic [sse_pkg::DIGIT_W-1:0]     mul_digit;
   logic [sse_pkg::MAG_W-1:0]       mul_res;

   logic                            angle_neg;
   logic [31:0]                     angle_mag;
   logic                            term_small;
   logic                            last_term;
   logic signed [sse_pkg::ACC_W:0]  m_signed;
   logic signed [sse_pkg::ACC_W:0]  acc_sum;
   logic signed [sse_pkg::ACC_W-1:0] acc_sat;
   logic signed [sse_pkg::ACC_W-1:0] acc_clamp;

   // Take the angle apart into sign and magnitude
   assign angle_neg = req_angle[31];
   assign angle_mag = angle_neg ? (32'd0 - req_angle) : req_angle;

   assign term_small = m_ff < sse_pkg::MAG_W'(thr_ff);
   assign last_term  = used_ff == sse_pkg::TERM_W'(sse_pkg::MAX_TERMS - 1);

   // Add the signed term and saturate the accumulator
   assign m_signed = $signed({2'b00, m_ff});
   assign acc_sum  = {acc_ff[sse_pkg::ACC_W-1], acc_ff} + (tneg_ff ? -m_signed : m_signed);

   always_comb begin
      if (acc_sum > sse_pkg::ACC_HI) begin
         acc_sat = sse_pkg::ACC_W'(sse_pkg::ACC_HI);
      end else if (acc_sum < sse_pkg::ACC_LO) begin
         acc_sat = sse_pkg::ACC_W'(sse_pkg::ACC_LO);
      end else begin
         acc_sat = sse_pkg::ACC_W'(acc_sum);
      end
   end

   // Clamp the final sum to plus or minus one
   always_comb begin
      if (acc_ff > sse_pkg::ONE_Q30) begin
         acc_clamp = sse_pkg::ONE_Q30;
      end else if (acc_ff < sse_pkg::NEG_ONE_Q30) begin
         acc_clamp = sse_pkg::NEG_ONE_Q30;
      end else begin
         acc_clamp = acc_ff;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sse_pkg::ST_IDLE: begin
            if (start) state_in = sse_pkg::ST_SQ;
         end
         sse_pkg::ST_SQ: begin
            if (dig_ff == 2'd0) state_in = sse_pkg::ST_SQ_END;
         end
         sse_pkg::ST_SQ_END: state_in = sse_pkg::ST_ACC;
         sse_pkg::ST_ACC: begin
            if (term_small || last_term) state_in = sse_pkg::ST_OUT;
            else                         state_in = sse_pkg::ST_MX;
         end
         sse_pkg::ST_MX: begin
            if (dig_ff == 2'd0) state_in = sse_pkg::ST_MX_END;
         end
         sse_pkg::ST_MX_END: state_in = sse_pkg::ST_MR;
         sse_pkg::ST_MR: begin
            if (dig_ff == 2'd0) state_in = sse_pkg::ST_MR_END;
         end
         sse_pkg::ST_MR_END: state_in = sse_pkg::ST_ACC;
         sse_pkg::ST_OUT:    state_in = sse_pkg::ST_IDLE;
         default:            state_in = sse_pkg::ST_IDLE;
      endcase
   end

   // Multiplier control and operand selection
   always_comb begin
      mul_ctrl.step  = 1'b0;
      mul_ctrl.clear = 1'b0;
      mul_ctrl.shift = sse_pkg::SH_32;
      mul_a          = sse_pkg::OPA_W'(m_ff);
      b_word         = 48'(sse_pkg::RECIP[used_ff[sse_pkg::IDX_W-1:0]]);
      unique case (state_ff)
         sse_pkg::ST_SQ: begin
            mul_ctrl.step  = 1'b1;
            mul_ctrl.clear = dig_ff == 2'd1;
            mul_a          = sse_pkg::OPA_W'(amag_ff);
            b_word         = 48'(amag_ff);
         end
         sse_pkg::ST_SQ_END: begin
            mul_ctrl.shift = sse_pkg::SH_26;
         end
         sse_pkg::ST_MX: begin
            mul_ctrl.step  = 1'b1;
            mul_ctrl.clear = dig_ff == 2'd2;
            b_word         = 48'(x2_ff);
         end
         sse_pkg::ST_MX_END: begin
            mul_ctrl.shift = sse_pkg::SH_30;
         end
         sse_pkg::ST_MR: begin
            mul_ctrl.step  = 1'b1;
            mul_ctrl.clear = dig_ff == 2'd1;
         end
         default: begin
            mul_ctrl.shift = sse_pkg::SH_32;
         end
      endcase
   end

   always_comb begin
      case (dig_ff)
         2'd2:    mul_digit = b_word[47:32];
         2'd1:    mul_digit = b_word[31:16];
         default: mul_digit = b_word[15:0];
      endcase
   end

   assign busy = state_ff != sse_pkg::ST_IDLE;

   sse_mul_unit u_mul (
      .clock    (clock),
      .ctrl     (mul_ctrl),
      .op_a     (mul_a),
      .op_digit (mul_digit),
      .result   (mul_res)
   );

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sse_pkg::ST_IDLE;
         thr_ff       <= 21'd1;
         dig_ff       <= 2'd0;
         used_ff      <= '0;
         done_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= state_ff == sse_pkg::ST_OUT;
         if (csr_wr_en) thr_ff <= csr_wr_data;
         case (state_ff)
            sse_pkg::ST_IDLE: begin
               dig_ff  <= 2'd1;
               used_ff <= '0;
            end
            sse_pkg::ST_SQ, sse_pkg::ST_MX, sse_pkg::ST_MR: begin
               dig_ff <= dig_ff - 2'd1;
            end
            sse_pkg::ST_ACC: begin
               used_ff <= used_ff + sse_pkg::TERM_W'(1);
               done_ff <= term_small;
               dig_ff  <= 2'd2;
            end
            sse_pkg::ST_MX_END: begin
               dig_ff <= 2'd1;
            end
            default: begin
               dig_ff <= dig_ff;
            end
         endcase
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      case (state_ff)
         sse_pkg::ST_IDLE: begin
            if (start) begin
               amag_ff <= angle_mag;
               m_ff    <= sse_pkg::MAG_W'({angle_mag, 2'b00});
               tneg_ff <= angle_neg;
               acc_ff  <= '0;
            end
         end
         sse_pkg::ST_SQ_END: x2_ff  <= mul_res[36:0];
         sse_pkg::ST_ACC:    acc_ff <= acc_sat;
         sse_pkg::ST_MX_END: m_ff   <= mul_res;
         sse_pkg::ST_MR_END: begin
            m_ff    <= mul_res;
            tneg_ff <= !tneg_ff;
         end
         sse_pkg::ST_OUT: begin
            rsp_sine_ff  <= 32'(acc_clamp);
            rsp_terms_ff <= (8'(used_ff) > 8'd63) ? 6'd63 : 6'(used_ff);
            rsp_nc_ff    <= !done_ff;
         end
         default: begin
            acc_ff <= acc_ff;
         end
      endcase
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_sine_value    = rsp_sine_ff;
   assign rsp_terms_used    = rsp_terms_ff;
   assign rsp_not_converged = rsp_nc_ff;

   // A result strobe comes only once the sequencer has returned to idle
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobe while sequencer busy");

   // An accepted item keeps the block busy in the next cycle
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (!reset && start && !busy) |=> busy)
      else $error("accepted item did not raise busy");

   // Every result sums at least one term
   a_terms_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_terms_used != 6'd0))
      else $error("result with zero terms");

   // The sine value stays within plus or minus one
   a_sine_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($signed(rsp_sine_value) <= 32'sh4000_0000
                  && $signed(rsp_sine_value) >= -32'sh4000_0000))
      else $error("sine value out of range");

endmodule
